FILE: src/sfsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsa_pkg
// Shared types and constants of the spring force scatter accumulator.
// ----------------------------------------------------------------------------
package sfsa_pkg;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SPRING = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_DIFF,
    ST_SQ,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DEF,
    ST_ST_MUL,
    ST_ST_SCALE,
    ST_K_MUL,
    ST_K_HOLD,
    ST_P_LO,
    ST_P_HI,
    ST_P_SUM,
    ST_DIV,
    ST_FA_RD,
    ST_FA_WR,
    ST_FB_RD,
    ST_FB_WR,
    ST_OUT
  } state_t;

  // Divider geometry: numerator k*|def|*|d|, divisor len*256, quotient force.
  localparam int NUM_W     = 98;
  localparam int DEN_W     = 41;
  localparam int QUO_W     = 58;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: src/sfsa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsa_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfsa_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sfsa_pkg::NUM_W-1:0]   num,
  input  logic [sfsa_pkg::DEN_W-1:0]   den,
  output sfsa_pkg::div_status_t        status,
  output logic [sfsa_pkg::QUO_W-1:0]   quot
);

  logic [sfsa_pkg::DEN_W-1:0]     rem;
  logic [sfsa_pkg::DEN_W-1:0]     den_q;
  logic [sfsa_pkg::NUM_W-1:0]     qn;
  logic [sfsa_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;
  logic                           done;
  logic [sfsa_pkg::DEN_W:0]       trial;
  logic                           ge;

  assign trial = {rem, qn[sfsa_pkg::NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= sfsa_pkg::DIV_CNT_W'(sfsa_pkg::NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sfsa_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder always stays below the divisor, so it fits DEN_W bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      qn    <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? sfsa_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[sfsa_pkg::DEN_W-1:0];
      qn  <= {qn[sfsa_pkg::NUM_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quot        = qn[sfsa_pkg::QUO_W-1:0];

endmodule

FILE: src/spring_force_scatter_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_scatter_accumulator
// Node table of positions, force accumulators and peak stress, updated by
// springs through read-modify-write on block memories.
// ----------------------------------------------------------------------------
// After reset a clearing pass zeroes the force and stress memory, during
// which no transaction is accepted. Items are then taken one at a time. A
// spring runs two position reads, three squarings on the shared multiplier,
// a bit-serial square root, then for each axis two partial products and a
// pass through the restoring divider; reads and writes of the force memory
// finish the update of both end nodes. A spring of zero length skips the
// divider.
module spring_force_scatter_accumulator #(
  parameter int NODE_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [19:0]        write_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [9:0]         node_a,
  input  logic [9:0]         node_b,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [30:0]        spring_rest,
  input  logic [31:0]        stiffness,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         node_index,
  output logic signed [47:0] force_x,
  output logic signed [47:0] force_y,
  output logic signed [47:0] force_z,
  output logic [47:0]        peak_stress
);

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_COUNT - 1);

  // Saturating 48-bit accumulate of a signed force step.
  function automatic logic [47:0] sat_add(input logic [47:0] acc,
                                          input logic [58:0] f,
                                          input logic        sub);
    logic signed [60:0] s;
    s = $signed({{13{acc[47]}}, acc});
    if (sub) s = s - $signed({{2{f[58]}}, f});
    else     s = s + $signed({{2{f[58]}}, f});
    if (s > $signed(61'h7FFF_FFFF_FFFF)) return 48'h7FFF_FFFF_FFFF;
    if (s < -$signed(61'h8000_0000_0000)) return 48'h8000_0000_0000;
    return s[47:0];
  endfunction

  sfsa_pkg::state_t state, state_next;

  // Memories.
  logic [95:0]  pos_mem [NODE_COUNT];
  logic [191:0] frc_mem [NODE_COUNT];
  logic [95:0]  pos_q;
  logic [191:0] frc_q;
  logic [ADDR_W-1:0] pos_rd_addr, frc_rd_addr, frc_wr_addr;
  logic              pos_we, frc_we;
  logic [191:0]      frc_wr_data;

  // Item and datapath registers.
  logic [19:0]  modulus;
  logic [9:0]   reg_a, reg_b;
  logic [30:0]  reg_rest;
  logic [31:0]  reg_k;
  logic         reg_zero;
  logic [ADDR_W-1:0] clr_addr;
  logic [95:0]  pa;
  logic [32:0]  mag [3];
  logic         dneg [3];
  logic [1:0]   ax;
  logic [65:0]  prod;
  logic [32:0]  mul_a, mul_b;
  logic [65:0]  sum_sq;
  logic [65:0]  rad;
  logic [36:0]  srem;
  logic [32:0]  root;
  logic [5:0]   scnt;
  logic [32:0]  absdef;
  logic         defneg;
  logic [47:0]  stress;
  logic [64:0]  m;
  logic [sfsa_pkg::NUM_W-1:0] num;
  logic [sfsa_pkg::QUO_W-1:0] fq [3];
  logic         fneg [3];

  logic                        div_start;
  sfsa_pkg::div_status_t       div_status;
  logic [sfsa_pkg::QUO_W-1:0]  div_quot;
  logic [sfsa_pkg::NUM_W-1:0]  div_num;

  logic accept, a_ok, b_ok, out_load;
  logic [36:0] sq_t, sq_trial;
  logic [33:0] def_w;
  logic [63:0] st_x, st_y;
  logic [58:0] fs [3];

  assign accept = in_valid && !in_stall;
  assign a_ok   = 32'(node_a) < 32'(NODE_COUNT);
  assign b_ok   = 32'(node_b) < 32'(NODE_COUNT);
  assign in_stall = (state != sfsa_pkg::ST_IDLE);
  assign out_load = (state == sfsa_pkg::ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fs[i] = fneg[i] ? 59'(-{1'b0, fq[i]}) : {1'b0, fq[i]};
    end
  end

  assign sq_t     = {srem[34:0], rad[65:64]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign def_w    = {1'b0, root} - {3'b000, reg_rest};
  assign st_x     = 64'(prod[52:0]);
  assign st_y     = (st_x << 10) - (st_x << 4) - (st_x << 3);
  assign div_num  = num + sfsa_pkg::NUM_W'({prod, 33'd0});

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[ADDR_W'(node_a)] <= {coord_x, coord_y, coord_z};
    pos_q <= pos_mem[pos_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (frc_we) frc_mem[frc_wr_addr] <= frc_wr_data;
    frc_q <= frc_mem[frc_rd_addr];
  end

  // --------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= sfsa_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    pos_we      = 1'b0;
    pos_rd_addr = ADDR_W'(reg_a);
    frc_we      = 1'b0;
    frc_wr_addr = ADDR_W'(reg_a);
    frc_wr_data = '0;
    frc_rd_addr = ADDR_W'(reg_a);
    mul_a       = mag[ax];
    mul_b       = mag[ax];
    div_start   = 1'b0;
    case (state)
      sfsa_pkg::ST_CLEAR: begin
        frc_we      = 1'b1;
        frc_wr_addr = clr_addr;
        if (clr_addr == LAST_ADDR) state_next = sfsa_pkg::ST_IDLE;
      end
      sfsa_pkg::ST_IDLE: begin
        frc_rd_addr = ADDR_W'(node_a);
        if (accept) begin
          case (sfsa_pkg::kind_t'(kind))
            sfsa_pkg::KIND_LOAD: begin
              if (a_ok) begin
                pos_we      = 1'b1;
                frc_we      = 1'b1;
                frc_wr_addr = ADDR_W'(node_a);
              end
            end
            sfsa_pkg::KIND_SPRING: begin
              if (a_ok && b_ok) state_next = sfsa_pkg::ST_RD_A;
            end
            sfsa_pkg::KIND_READ: state_next = sfsa_pkg::ST_OUT;
            default: state_next = sfsa_pkg::ST_IDLE;
          endcase
        end
      end
      sfsa_pkg::ST_RD_A: state_next = sfsa_pkg::ST_RD_B;
      sfsa_pkg::ST_RD_B: begin
        pos_rd_addr = ADDR_W'(reg_b);
        state_next  = sfsa_pkg::ST_DIFF;
      end
      sfsa_pkg::ST_DIFF:   state_next = sfsa_pkg::ST_SQ;
      sfsa_pkg::ST_SQ:     state_next = sfsa_pkg::ST_SQ_ACC;
      sfsa_pkg::ST_SQ_ACC: state_next = (ax == 2'd2) ? sfsa_pkg::ST_SQRT : sfsa_pkg::ST_SQ;
      sfsa_pkg::ST_SQRT:   if (scnt == 6'd0) state_next = sfsa_pkg::ST_DEF;
      sfsa_pkg::ST_DEF:    state_next = sfsa_pkg::ST_ST_MUL;
      sfsa_pkg::ST_ST_MUL: begin
        mul_a      = absdef;
        mul_b      = 33'(modulus);
        state_next = sfsa_pkg::ST_ST_SCALE;
      end
      sfsa_pkg::ST_ST_SCALE: state_next = sfsa_pkg::ST_K_MUL;
      sfsa_pkg::ST_K_MUL: begin
        mul_a      = absdef;
        mul_b      = 33'(reg_k);
        state_next = sfsa_pkg::ST_K_HOLD;
      end
      sfsa_pkg::ST_K_HOLD: begin
        state_next = (root == '0) ? sfsa_pkg::ST_FA_RD : sfsa_pkg::ST_P_LO;
      end
      sfsa_pkg::ST_P_LO: begin
        mul_a      = m[32:0];
        state_next = sfsa_pkg::ST_P_HI;
      end
      sfsa_pkg::ST_P_HI: begin
        mul_a      = {1'b0, m[64:33]};
        state_next = sfsa_pkg::ST_P_SUM;
      end
      sfsa_pkg::ST_P_SUM: begin
        div_start  = 1'b1;
        state_next = sfsa_pkg::ST_DIV;
      end
      sfsa_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = (ax == 2'd2) ? sfsa_pkg::ST_FA_RD : sfsa_pkg::ST_P_LO;
        end
      end
      sfsa_pkg::ST_FA_RD: state_next = sfsa_pkg::ST_FA_WR;
      sfsa_pkg::ST_FA_WR: begin
        frc_we      = 1'b1;
        frc_wr_data = {sat_add(frc_q[191:144], fs[0], 1'b0),
                       sat_add(frc_q[143:96],  fs[1], 1'b0),
                       sat_add(frc_q[95:48],   fs[2], 1'b0),
                       (stress > frc_q[47:0]) ? stress : frc_q[47:0]};
        state_next  = sfsa_pkg::ST_FB_RD;
      end
      sfsa_pkg::ST_FB_RD: begin
        frc_rd_addr = ADDR_W'(reg_b);
        state_next  = sfsa_pkg::ST_FB_WR;
      end
      sfsa_pkg::ST_FB_WR: begin
        frc_rd_addr = ADDR_W'(reg_b);
        frc_we      = 1'b1;
        frc_wr_addr = ADDR_W'(reg_b);
        frc_wr_data = {sat_add(frc_q[191:144], fs[0], 1'b1),
                       sat_add(frc_q[143:96],  fs[1], 1'b1),
                       sat_add(frc_q[95:48],   fs[2], 1'b1),
                       (stress > frc_q[47:0]) ? stress : frc_q[47:0]};
        state_next  = sfsa_pkg::ST_IDLE;
      end
      sfsa_pkg::ST_OUT: if (out_load) state_next = sfsa_pkg::ST_IDLE;
      default: state_next = sfsa_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus  <= 20'd200000;
      clr_addr <= '0;
    end else begin
      if (write_enable) modulus <= write_data;
      if (state == sfsa_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      reg_a    <= node_a;
      reg_b    <= node_b;
      reg_rest <= spring_rest;
      reg_k    <= stiffness;
      reg_zero <= !a_ok;
    end
    case (state)
      sfsa_pkg::ST_RD_B: pa <= pos_q;
      sfsa_pkg::ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          logic signed [32:0] d;
          d = $signed({pos_q[95-32*i], pos_q[95-32*i -: 32]})
            - $signed({pa[95-32*i], pa[95-32*i -: 32]});
          dneg[i] <= d[32];
          mag[i]  <= d[32] ? 33'(-d) : 33'(d);
        end
        ax     <= 2'd0;
        sum_sq <= '0;
      end
      sfsa_pkg::ST_SQ_ACC: begin
        sum_sq <= sum_sq + prod;
        rad    <= sum_sq + prod;
        srem   <= '0;
        root   <= '0;
        scnt   <= 6'd32;
        ax     <= ax + 1'b1;
      end
      sfsa_pkg::ST_SQRT: begin
        if (sq_t >= sq_trial) begin
          srem <= sq_t - sq_trial;
          root <= {root[31:0], 1'b1};
        end else begin
          srem <= sq_t;
          root <= {root[31:0], 1'b0};
        end
        rad  <= {rad[63:0], 2'b00};
        scnt <= scnt - 1'b1;
      end
      sfsa_pkg::ST_DEF: begin
        defneg <= def_w[33];
        absdef <= def_w[33] ? 33'(-def_w) : def_w[32:0];
      end
      sfsa_pkg::ST_ST_SCALE: stress <= 48'(st_y >> 24);
      sfsa_pkg::ST_K_HOLD: begin
        m  <= prod[64:0];
        ax <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          fq[i]   <= '0;
          fneg[i] <= 1'b0;
        end
      end
      sfsa_pkg::ST_P_HI: num <= sfsa_pkg::NUM_W'(prod);
      sfsa_pkg::ST_DIV: begin
        if (div_status.done) begin
          fq[ax]   <= div_quot;
          fneg[ax] <= defneg ^ dneg[ax];
          ax       <= ax + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: a finished read may wait here while the next item runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      node_index  <= reg_a;
      force_x     <= reg_zero ? '0 : frc_q[191:144];
      force_y     <= reg_zero ? '0 : frc_q[143:96];
      force_z     <= reg_zero ? '0 : frc_q[95:48];
      peak_stress <= reg_zero ? '0 : frc_q[47:0];
    end
  end

  sfsa_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    ({root, 8'd0}),
    .status (div_status),
    .quot   (div_quot)
  );

  // -------------------------------------------------------------- assertions
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == sfsa_pkg::ST_CLEAR) |-> in_stall)
    else $error("transaction accepted during clearing pass");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider restarted while busy");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == sfsa_pkg::ST_OUT))
    else $error("result raised outside the read state");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_status.done |-> (state == sfsa_pkg::ST_DIV))
    else $error("divider finished with no spring waiting");

endmodule
